// ===== hdl/voxel_face_culling_mesher_defines.svh =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_MESHER_DEFINES_SVH
`define VOXEL_FACE_CULLING_MESHER_DEFINES_SVH

// check prop on every edge outside reset
`define VFCM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check prop on every edge, reset included
`define VFCM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher package
// Item types, shape and axis codes shared by the mesher modules.
// ----------------------------------------------------------------------------
package vfcm_pkg;

  localparam int CHUNK_EDGE = 16;
  localparam int COORD_W    = 4;
  localparam int FACE_W     = 15;
  localparam int QUAD_W     = 6;
  localparam int VERTEX_W   = 17;
  localparam int SIDES      = 6;

  localparam logic [1:0] SHAPE_NONE = 2'd0;
  localparam logic [1:0] SHAPE_FULL = 2'd1;
  localparam logic [1:0] SHAPE_SLAB = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [COORD_W-1:0] cell_z;
    logic [1:0]         cell_shape;
    logic [1:0]         shape_x_minus;
    logic [1:0]         shape_x_plus;
    logic [1:0]         shape_y_minus;
    logic [1:0]         shape_y_plus;
    logic [1:0]         shape_z_minus;
    logic [1:0]         shape_z_plus;
    logic               chunk_start;
  } voxel_t;

  typedef struct packed {
    logic [1:0]          face_axis;
    logic                facing_positive;
    logic [QUAD_W-1:0]   plane_pos;
    logic [QUAD_W-1:0]   u_low;
    logic [QUAD_W-1:0]   u_high;
    logic [QUAD_W-1:0]   v_low;
    logic [QUAD_W-1:0]   v_high;
    logic [VERTEX_W-1:0] first_vertex;
    logic                last_face;
  } quad_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               slab;
    logic [SIDES-1:0]   mask;
    logic               chunk_start;
  } job_t;

endpackage

// ===== hdl/vfcm_front.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher front end
// Clamps the cell position and works out the mask of exposed faces.
// ----------------------------------------------------------------------------
module vfcm_front (
  input  vfcm_pkg::voxel_t voxel,
  input  logic             push,
  input  logic             q_full,
  output vfcm_pkg::job_t   job,
  output logic             job_push
);

  function automatic logic [vfcm_pkg::COORD_W-1:0] clamp(
    input logic [vfcm_pkg::COORD_W-1:0] c
  );
    logic [vfcm_pkg::COORD_W-1:0] r;
    if ({1'b0, c} >= (vfcm_pkg::COORD_W+1)'(vfcm_pkg::CHUNK_EDGE)) begin
      r = vfcm_pkg::COORD_W'(vfcm_pkg::CHUNK_EDGE - 1);
    end else begin
      r = c;
    end
    return r;
  endfunction

  logic [1:0] nb [vfcm_pkg::SIDES];
  logic       self_full;
  logic       self_slab;

  always_comb begin
    nb[0] = voxel.shape_x_minus;
    nb[1] = voxel.shape_x_plus;
    nb[2] = voxel.shape_y_minus;
    nb[3] = voxel.shape_y_plus;
    nb[4] = voxel.shape_z_minus;
    nb[5] = voxel.shape_z_plus;
    self_full = (voxel.cell_shape == vfcm_pkg::SHAPE_FULL);
    self_slab = (voxel.cell_shape == vfcm_pkg::SHAPE_SLAB);
  end

  always_comb begin
    job.x           = clamp(voxel.cell_x);
    job.y           = clamp(voxel.cell_y);
    job.z           = clamp(voxel.cell_z);
    job.slab        = self_slab;
    job.chunk_start = voxel.chunk_start;
    for (int i = 0; i < vfcm_pkg::SIDES; i++) begin
      logic side_y;
      logic top_face;
      logic hides;
      side_y   = (i == 2) || (i == 3);
      top_face = self_slab && (i == 3);
      hides    = (nb[i] == vfcm_pkg::SHAPE_FULL) ||
                 (self_slab && (nb[i] == vfcm_pkg::SHAPE_SLAB) && !side_y);
      job.mask[i] = (self_full || self_slab) && (top_face || !hides);
    end
  end

  assign job_push = push && !q_full;

endmodule

// ===== hdl/vfcm_queue.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher job queue
// Two-entry queue between the front end and the quad sequencer.
// ----------------------------------------------------------------------------
module vfcm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vfcm_pkg::job_t din,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output vfcm_pkg::job_t head
);

  vfcm_pkg::job_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = mem[rd_ptr];

endmodule

// ===== hdl/vfcm_back.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher quad sequencer
// Emits exposed faces to the output stage, one quad per cycle when it is free.
// ----------------------------------------------------------------------------
module vfcm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  vfcm_pkg::job_t  q_head,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output vfcm_pkg::quad_t quad
);

  vfcm_pkg::job_t              job;
  logic [vfcm_pkg::SIDES-1:0]  rem;
  logic [vfcm_pkg::SIDES-1:0]  rem_after;
  logic [vfcm_pkg::SIDES-1:0]  rem_next;
  logic [vfcm_pkg::FACE_W-1:0] cnt;
  logic [vfcm_pkg::FACE_W-1:0] cnt_next;
  logic                        out_valid;
  logic                        out_valid_next;
  logic                        slot_free;
  logic                        emit;
  logic [2:0]                  idx;
  logic [1:0]                  axis;
  logic [1:0]                  ua;
  logic [1:0]                  va;
  logic                        positive;
  vfcm_pkg::quad_t             quad_next;

  function automatic logic [vfcm_pkg::COORD_W-1:0] coord_of(
    input vfcm_pkg::job_t j,
    input logic [1:0]     a
  );
    logic [vfcm_pkg::COORD_W-1:0] r;
    unique case (a)
      vfcm_pkg::AXIS_Y: r = j.y;
      vfcm_pkg::AXIS_Z: r = j.z;
      default:          r = j.x;
    endcase
    return r;
  endfunction

  function automatic logic [vfcm_pkg::QUAD_W-1:0] span_of(
    input vfcm_pkg::job_t j,
    input logic [1:0]     a
  );
    logic [vfcm_pkg::QUAD_W-1:0] r;
    if (a == vfcm_pkg::AXIS_Y && j.slab) begin
      r = vfcm_pkg::QUAD_W'(1);
    end else begin
      r = vfcm_pkg::QUAD_W'(2);
    end
    return r;
  endfunction

  function automatic logic [vfcm_pkg::QUAD_W-1:0] low_of(
    input vfcm_pkg::job_t j,
    input logic [1:0]     a
  );
    return vfcm_pkg::QUAD_W'({coord_of(j, a), 1'b0});
  endfunction

  always_comb begin
    idx = 3'd0;
    for (int i = vfcm_pkg::SIDES - 1; i >= 0; i--) begin
      if (rem[i]) begin
        idx = 3'(i);
      end
    end
  end

  always_comb begin
    axis     = idx[2:1];
    positive = idx[0];
    unique case (axis)
      vfcm_pkg::AXIS_Y: begin
        ua = vfcm_pkg::AXIS_Z;
        va = vfcm_pkg::AXIS_X;
      end
      vfcm_pkg::AXIS_Z: begin
        ua = vfcm_pkg::AXIS_X;
        va = vfcm_pkg::AXIS_Y;
      end
      default: begin
        ua = vfcm_pkg::AXIS_Y;
        va = vfcm_pkg::AXIS_Z;
      end
    endcase
  end

  always_comb begin
    slot_free = !out_valid || pop;
    emit      = (|rem) && slot_free;
    rem_after = emit ? (rem & ~(vfcm_pkg::SIDES'(1) << idx)) : rem;
    q_pop     = !q_empty && (rem_after == '0);
    rem_next  = q_pop ? q_head.mask : rem_after;
    cnt_next  = emit ? cnt + vfcm_pkg::FACE_W'(1) : cnt;
    if (q_pop && q_head.chunk_start) begin
      cnt_next = '0;
    end
    out_valid_next = emit ? 1'b1 : (pop ? 1'b0 : out_valid);
  end

  always_comb begin
    quad_next.face_axis       = axis;
    quad_next.facing_positive = positive;
    quad_next.plane_pos       = low_of(job, axis) +
                                (positive ? span_of(job, axis) : '0);
    quad_next.u_low           = low_of(job, ua);
    quad_next.u_high          = low_of(job, ua) + span_of(job, ua);
    quad_next.v_low           = low_of(job, va);
    quad_next.v_high          = low_of(job, va) + span_of(job, va);
    quad_next.first_vertex    = {cnt, 2'b00};
    quad_next.last_face       = (rem_after == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      rem       <= rem_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
    end
    if (emit) begin
      quad <= quad_next;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== hdl/voxel_face_culling_mesher.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher
// Turns voxel cells into culled quads with running vertex indices.
// ----------------------------------------------------------------------------
// A cell is taken while the two-entry job queue has room. The quad sequencer
// then sends one quad per cycle while the output stage has room, one exposed
// face at a time; an empty or fully hidden cell still takes a turn without
// sending a quad, and the next cell starts once the last face is sent.
// The output stage holds one quad and refills in the cycle it is popped.
module voxel_face_culling_mesher (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  vfcm_pkg::voxel_t voxel,
  output logic             empty,
  input  logic             pop,
  output vfcm_pkg::quad_t  quad
);

  vfcm_pkg::job_t job;
  vfcm_pkg::job_t q_head;
  logic           job_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  vfcm_front u_front (
    .voxel    (voxel),
    .push     (push),
    .q_full   (q_full),
    .job      (job),
    .job_push (job_push)
  );

  vfcm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  vfcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .quad    (quad)
  );

  assign full = q_full;

endmodule

// ===== hdl/vfcm_checker.sv =====
// ----------------------------------------------------------------------------
// Voxel face culling mesher checker
// Port-level checks on reset, output hold, vertex alignment and quad geometry.
// ----------------------------------------------------------------------------
`include "voxel_face_culling_mesher_defines.svh"

module vfcm_checker (
  input logic             clk,
  input logic             rst,
  input logic             full,
  input logic             empty,
  input logic             pop,
  input vfcm_pkg::quad_t  quad
);

  `VFCM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (empty && !full), "not idle after reset")
  `VFCM_ASSERT(a_out_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(quad)), "quad dropped")
  `VFCM_ASSERT(a_vertex_align, clk, rst, !empty |-> (quad.first_vertex[1:0] == 2'b00), "vertex index")
  `VFCM_ASSERT(a_bounds, clk, rst, !empty |-> ((quad.u_high > quad.u_low) && (quad.v_high > quad.v_low)), "quad bounds")

endmodule

bind voxel_face_culling_mesher vfcm_checker u_vfcm_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .quad  (quad)
);
